// ----- hdl/ssi_pkg.sv -----
// Shared types and codes for the sorted set insert block.
package ssi_pkg;

	// Fixed field widths of the item and result ports
	localparam int ACTION_W = 2;
	localparam int KEY_W    = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W  = 7;

	// Action codes (the unused code acts as a locate)
	localparam logic [ACTION_W-1:0] ACT_LOCATE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;   // take a new item and compare it against every cell
		logic apply;     // encode the position, update cells, count and result
	} ssi_cmd_t;

endpackage

// ----- hdl/ssi_ctrl.sv -----
// Controller state machine: sequences capture and apply, drives busy and done.
module ssi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output ssi_pkg::ssi_cmd_t cmd
);
	import ssi_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_UPD;
						busy_q  <= 1'b1;
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Commands to the datapath
	assign cmd.capture = start && !busy_q;
	assign cmd.apply   = (state_q == ST_UPD);

	assign busy = busy_q;
	assign done = done_q;

`ifndef ASSERT_OFF
	// every accepted item gets its result strobe once the update state ends
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> ##1 done_q)
		else $error("accepted item produced no result strobe");

	// a result strobe comes only in the idle state and follows an apply
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE) && $past(cmd.apply))
		else $error("result strobe outside the apply sequence");
`endif

endmodule

// ----- hdl/ssi_dpath.sv -----
// Datapath: a row of key cells with parallel compare, position encode and shift insert.
module ssi_dpath #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssi_pkg::ssi_cmd_t              cmd,
	input  logic [ssi_pkg::ACTION_W-1:0]   action,
	input  logic [ssi_pkg::KEY_W-1:0]      key_value,
	output logic [ssi_pkg::POS_W-1:0]      position,
	output logic [ssi_pkg::STATUS_W-1:0]   status,
	output logic [ssi_pkg::TOTAL_W-1:0]    entry_total
);
	import ssi_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_BITS-1:0] key_in;
	logic [KEY_BITS-1:0] key_q;
	logic [ACTION_W-1:0] act_q;
	logic [KEY_BITS-1:0] entries_q [CAPACITY];
	logic [CW-1:0]       count_q;
	logic [CAPACITY-1:0] lt_c, eq_c, lt_q, eq_q;
	logic [CAPACITY:0]   first_c;
	logic [CW-1:0]       pos_c;
	logic                found_c;
	logic                full_c;
	logic                do_insert;
	logic [CW-1:0]       count_nxt;
	logic [CW-1:0]       pos_out;
	logic [STATUS_W-1:0] stat_c;
	logic [CW+POS_W-1:0] pos_ext;
	logic [CW+TOTAL_W-1:0] tot_ext;
	logic [POS_W-1:0]    position_q;
	logic [STATUS_W-1:0] status_q;
	logic [TOTAL_W-1:0]  total_q;

	// Key as stored: low KEY_BITS of the port, zero-extended if wider
	if (KEY_BITS <= KEY_W) begin : g_key_narrow
		assign key_in = key_value[KEY_BITS-1:0];
	end else begin : g_key_wide
		assign key_in = {{(KEY_BITS-KEY_W){1'b0}}, key_value};
	end

	// Parallel compare of every valid cell against the incoming key
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_c[i] = (CW'(i) < count_q) && (entries_q[i] < key_in);
			eq_c[i] = (CW'(i) < count_q) && (entries_q[i] == key_in);
		end
	end

	// Capture the item and the compare vectors
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q <= key_in;
			act_q <= action;
			lt_q  <= lt_c;
			eq_q  <= eq_c;
		end
	end

	// lt_q is a thermometer code; mark its first zero (lower bound)
	always_comb begin
		first_c[0] = !lt_q[0];
		for (int i = 1; i < CAPACITY; i++)
			first_c[i] = lt_q[i-1] && !lt_q[i];
		first_c[CAPACITY] = lt_q[CAPACITY-1];
	end

	// One-hot to index encode of the lower bound
	always_comb begin
		pos_c = '0;
		for (int i = 0; i <= CAPACITY; i++)
			pos_c = pos_c | (first_c[i] ? CW'(i) : '0);
	end

	assign found_c   = |(first_c[CAPACITY-1:0] & eq_q);
	assign full_c    = (count_q == CW'(CAPACITY));
	assign do_insert = cmd.apply && (act_q == ACT_INSERT) && !found_c && !full_c;

	// Status and next count
	always_comb begin
		count_nxt = count_q;
		pos_out   = pos_c;
		case (act_q)
			ACT_CLEAR: begin
				stat_c    = STAT_CLEARED;
				count_nxt = '0;
				pos_out   = '0;
			end
			ACT_INSERT: begin
				if (found_c)
					stat_c = STAT_PRESENT;
				else if (full_c)
					stat_c = STAT_FULL;
				else begin
					stat_c    = STAT_INSERTED;
					count_nxt = count_q + CW'(1);
				end
			end
			default: stat_c = found_c ? STAT_PRESENT : STAT_ABSENT;
		endcase
	end

	// Cells: those below the lower bound hold, the one at it takes the key,
	// the ones above shift up from their neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (do_insert && !lt_q[i])
					entries_q[i] <= key_q;
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (do_insert && !lt_q[i])
					entries_q[i] <= first_c[i] ? key_q : entries_q[i-1];
			end
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.apply)
			count_q <= count_nxt;
	end

	// Result register, truncated to the port widths
	assign pos_ext = {{POS_W{1'b0}}, pos_out};
	assign tot_ext = {{TOTAL_W{1'b0}}, count_nxt};

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			position_q <= pos_ext[POS_W-1:0];
			status_q   <= stat_c;
			total_q    <= tot_ext[TOTAL_W-1:0];
		end
	end

	assign position    = position_q;
	assign status      = status_q;
	assign entry_total = total_q;

`ifndef ASSERT_OFF
	// fill count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// count moves by at most one per item, or drops to zero on clear
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> (count_q == $past(count_q)) ||
			(count_q == $past(count_q) + CW'(1)) || (count_q == '0))
		else $error("entry count changed by an illegal step");

	// compare vector is a thermometer, so exactly one lower-bound mark
	a_one_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> $onehot(first_c))
		else $error("lower bound is not unique");
`endif

endmodule

// ----- hdl/sorted_set_insert.sv -----
// Top level of the sorted set insert block: controller plus cell datapath.
//
// Keeps an ascending list of distinct keys in CAPACITY compare-and-shift
// cells. An item is taken when start is high and busy is low; busy then
// stays high for one cycle and the result appears on position, status and
// entry_total for exactly one cycle with done high, in the cycle after that.
// For each item, in the accept cycle the key is compared against every
// cell at once, in the next cycle the lower-bound position is encoded and,
// on an insert, the cells above it shift up by one. A new item may be
// started whenever busy is low, and that includes the cycle in which the
// previous result is on done. The receiver cannot hold results off:
// whatever is on the ports while done is high must be taken then. No
// clearing pass runs after reset; the list starts empty and is usable at once.
module sorted_set_insert #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ssi_pkg::ACTION_W-1:0] action,
	input  logic [ssi_pkg::KEY_W-1:0]    key_value,
	output logic                         done,
	output logic [ssi_pkg::POS_W-1:0]    position,
	output logic [ssi_pkg::STATUS_W-1:0] status,
	output logic [ssi_pkg::TOTAL_W-1:0]  entry_total
);
	import ssi_pkg::*;

	ssi_cmd_t cmd;

	// Sequencing
	ssi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Key cells and result logic
	ssi_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.key_value   (key_value),
		.position    (position),
		.status      (status),
		.entry_total (entry_total)
	);

endmodule

// ----- sim/sorted_set_insert_tb.sv -----
// Self-checking testbench for the sorted set insert block: directed table plus random phases.
`timescale 1ns / 100ps

module sorted_set_insert_tb;
	import ssi_pkg::*;

	localparam int SET_CAPACITY = 64;
	localparam int ITEM_TARGET  = 900;
	localparam int CALM_TAIL    = 150;
	localparam int STALL_LIMIT  = 1000;
	localparam int REPORT_LIMIT = 10;

	// Unused action code, handled by the block as a locate
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [STATUS_W-1:0] stat;
		logic [TOTAL_W-1:0]  total;
	} set_result_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [KEY_W-1:0]    key;
		logic                typed;   // want holds a hand-written result
		set_result_t         want;
	} probe_row_t;

	localparam set_result_t NO_WANT = '0;

	// Directed items: extremes, every action, present/absent, front and back inserts
	probe_row_t probe_table [20] = '{
		'{ACT_LOCATE, 32'h0000_0000, 1'b1, '{7'd0, STAT_ABSENT,   7'd0}},
		'{ACT_SPARE,  32'hFFFF_FFFF, 1'b1, '{7'd0, STAT_ABSENT,   7'd0}},
		'{ACT_INSERT, 32'h0000_0000, 1'b1, '{7'd0, STAT_INSERTED, 7'd1}},
		'{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '{7'd1, STAT_INSERTED, 7'd2}},
		'{ACT_INSERT, 32'h0000_0000, 1'b1, '{7'd0, STAT_PRESENT,  7'd2}},
		'{ACT_LOCATE, 32'hFFFF_FFFF, 1'b1, '{7'd1, STAT_PRESENT,  7'd2}},
		'{ACT_LOCATE, 32'hFFFF_FFFE, 1'b0, NO_WANT},
		'{ACT_INSERT, 32'h8000_0000, 1'b0, NO_WANT},
		'{ACT_INSERT, 32'h7FFF_FFFF, 1'b0, NO_WANT},
		'{ACT_INSERT, 32'h5555_5555, 1'b0, NO_WANT},
		'{ACT_INSERT, 32'hAAAA_AAAA, 1'b0, NO_WANT},
		'{ACT_LOCATE, 32'h0000_0001, 1'b0, NO_WANT},
		'{ACT_SPARE,  32'hAAAA_AAAA, 1'b0, NO_WANT},
		'{ACT_INSERT, 32'hAAAA_AAAA, 1'b0, NO_WANT},
		'{ACT_CLEAR,  32'h1234_5678, 1'b1, '{7'd0, STAT_CLEARED,  7'd0}},
		'{ACT_LOCATE, 32'hFFFF_FFFF, 1'b1, '{7'd0, STAT_ABSENT,   7'd0}},
		'{ACT_INSERT, 32'h0000_0001, 1'b1, '{7'd0, STAT_INSERTED, 7'd1}},
		'{ACT_INSERT, 32'h0000_0000, 1'b0, NO_WANT},
		'{ACT_CLEAR,  32'h0000_0000, 1'b1, '{7'd0, STAT_CLEARED,  7'd0}},
		'{ACT_CLEAR,  32'hFFFF_FFFF, 1'b1, '{7'd0, STAT_CLEARED,  7'd0}}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ACTION_W-1:0] action;
	logic [KEY_W-1:0]    key_value;
	logic                done;
	logic [POS_W-1:0]    position;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0]  entry_total;

	// Shadow copy of the key list
	logic [KEY_W-1:0] set_keys [SET_CAPACITY];
	int unsigned      set_count;

	set_result_t pending_results [$];
	int unsigned status_tally [5];
	int unsigned items_sent;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit          idle_on;

	sorted_set_insert #(
		.CAPACITY(SET_CAPACITY),
		.KEY_BITS(KEY_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.key_value(key_value),
		.done(done),
		.position(position),
		.status(status),
		.entry_total(entry_total)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one item to the shadow list and return the result it should give
	function automatic set_result_t apply_to_set(input logic [ACTION_W-1:0] act,
	                                             input logic [KEY_W-1:0] key);
		set_result_t r;
		int unsigned lb;
		logic        hit;
		lb = 0;
		while (lb < set_count && set_keys[lb] < key)
			lb++;
		hit = (lb < set_count) && (set_keys[lb] == key);
		r.pos = POS_W'(lb);
		if (act == ACT_CLEAR) begin
			set_count = 0;
			r.pos = '0;
			r.stat = STAT_CLEARED;
		end else if (act != ACT_INSERT) begin
			r.stat = hit ? STAT_PRESENT : STAT_ABSENT;
		end else if (hit) begin
			r.stat = STAT_PRESENT;
		end else if (set_count >= SET_CAPACITY) begin
			r.stat = STAT_FULL;
		end else begin
			for (int unsigned u = set_count; u > lb; u--)
				set_keys[u] = set_keys[u-1];
			set_keys[lb] = key;
			set_count++;
			r.stat = STAT_INSERTED;
		end
		r.total = TOTAL_W'(set_count);
		status_tally[r.stat]++;
		return r;
	endfunction

	// Key mix: fresh wide keys, keys already held, their neighbors, extremes, a small range
	function automatic logic [KEY_W-1:0] pick_key(input bit fresh_bias);
		int unsigned      sel;
		logic [KEY_W-1:0] base;
		sel = $urandom_range(0, 9);
		if (fresh_bias && sel >= 7)
			sel = 0;
		base = (set_count > 0) ? set_keys[$urandom_range(0, set_count - 1)] : $urandom;
		case (sel)
			0, 1, 2: return $urandom;
			3, 4:    return base;
			5:       return $urandom_range(0, 1) ? base + 1'b1 : base - 1'b1;
			6:       return $urandom_range(0, 1) ? '0 : '1;
			default: return KEY_W'($urandom_range(0, 150));
		endcase
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("ERROR @%0t: %s", $time, what);
	endtask

	// Offer one item and hold it until the block takes it
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
	                         input logic typed, input set_result_t want);
		set_result_t got;
		start <= 1'b1;
		action <= act;
		key_value <= key;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		got = apply_to_set(act, key);
		pending_results.push_back(typed ? want : got);
		items_sent++;
	endtask

	// Random sender gap with junk on the item ports
	task automatic maybe_pause();
		if (idle_on && items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			action <= ACTION_W'($urandom);
			key_value <= $urandom;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Result checker
	always @(posedge clk) begin
		set_result_t want;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("result with none pending: pos=%0d status=%0d total=%0d",
					position, status, entry_total));
			end else begin
				want = pending_results.pop_front();
				if (position !== want.pos || status !== want.stat || entry_total !== want.total)
					note_mismatch($sformatf(
						"expected pos=%0d status=%0d total=%0d, got pos=%0d status=%0d total=%0d",
						want.pos, want.stat, want.total, position, status, entry_total));
			end
		end
	end

	// Watchdog: too long with no item taken and no result
	always @(posedge clk) begin
		if (!arst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus
	initial begin
		bit                  fill;
		int unsigned         roll;
		int unsigned         body;
		logic [ACTION_W-1:0] act;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_LOCATE;
		key_value = '0;
		set_count = 0;
		items_sent = 0;
		mismatch_count = 0;
		idle_on = 1'b1;
		foreach (status_tally[i])
			status_tally[i] = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (probe_table[i]) begin
			send_item(probe_table[i].act, probe_table[i].key, probe_table[i].typed,
				probe_table[i].want);
			maybe_pause();
		end
		drain_results();

		// Random phases, each opening with a clear; fill phases push past full
		fill = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			idle_on = $urandom_range(0, 3) != 0;
			if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 2) == 0)
				drain_results();
			send_item(ACT_CLEAR, $urandom, 1'b0, NO_WANT);
			maybe_pause();
			body = fill ? $urandom_range(130, 200) : $urandom_range(30, 120);
			// keep the total close to the item target
			if (body > ITEM_TARGET - items_sent)
				body = ITEM_TARGET - items_sent;
			repeat (body) begin
				roll = $urandom_range(0, 99);
				if (fill)
					act = (roll < 85) ? ACT_INSERT : (roll < 95) ? ACT_LOCATE : ACT_SPARE;
				else
					act = (roll < 50) ? ACT_INSERT : (roll < 82) ? ACT_LOCATE :
						(roll < 96) ? ACT_SPARE : ACT_CLEAR;
				send_item(act, pick_key(fill), 1'b0, NO_WANT);
				maybe_pause();
			end
			fill = $urandom_range(0, 3) == 0;
		end

		drain_results();
		repeat (8)
			@(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("Ran %0d items: %0d inserted, %0d already present, %0d dropped on full list,",
			items_sent, status_tally[STAT_INSERTED], status_tally[STAT_PRESENT],
			status_tally[STAT_FULL]);
		$display("  %0d located absent, %0d clears; %0d bad results",
			status_tally[STAT_ABSENT], status_tally[STAT_CLEARED], mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ssi_pkg.sv
hdl/ssi_ctrl.sv
hdl/ssi_dpath.sv
hdl/sorted_set_insert.sv
sim/sorted_set_insert_tb.sv
